// ----- rtl/usb_ep0_control_transfer_fsm_unit_defines.svh -----
// assertion macros shared by the endpoint-zero sequencer rtl
`ifndef USB_EP0_CONTROL_TRANSFER_FSM_UNIT_DEFINES_SVH
`define USB_EP0_CONTROL_TRANSFER_FSM_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define USBEP0_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define USBEP0_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/usbep0_pkg.sv -----
// types, codes and constants of the endpoint-zero sequencer
package usbep0_pkg;

  localparam int AddrW  = 7;
  localparam int CountW = 7;
  localparam int LenW   = 16;
  localparam int MpsW   = 7;

  localparam logic [MpsW-1:0] MpsReset = 7'd64;

  typedef enum logic [2:0] {
    PH_SETUP      = 3'd0,
    PH_IN_DATA    = 3'd1,
    PH_IN_STATUS  = 3'd2,
    PH_OUT_DATA   = 3'd3,
    PH_OUT_STATUS = 3'd4,
    PH_STALL      = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    NTF_NONE   = 2'd0,
    NTF_SETUP  = 2'd1,
    NTF_IN     = 2'd2,
    NTF_OUT    = 2'd3
  } notify_t;

  localparam logic KIND_EVENT    = 1'b0;
  localparam logic KIND_SET_ADDR = 1'b1;

  localparam logic [CountW-1:0] SetupCount = 7'd8;

  typedef struct packed {
    logic              kind;
    logic [AddrW-1:0]  address;
    logic              stalled_flag;
    logic              setup_end_flag;
    logic              rx_ready_flag;
    logic [CountW-1:0] rx_count;
    logic [LenW-1:0]   request_length;
    logic              request_in;
    logic              stall_request;
    logic [LenW-1:0]   in_bytes_left;
  } item_t;

  typedef struct packed {
    notify_t          notify;
    logic             clear_stalled;
    logic             clear_setup_end;
    logic             rx_done;
    logic             tx_ready;
    logic             data_end;
    logic             send_stall;
    logic             address_write;
    logic [AddrW-1:0] address_out;
    phase_t           phase;
  } result_t;

  typedef struct packed {
    phase_t           phase;
    logic [AddrW-1:0] pend_addr;
    logic [LenW-1:0]  saved_len;
  } ctx_t;

endpackage

// ----- rtl/usbep0_seq.sv -----
// next-phase and command decode for one endpoint-zero item
module usbep0_seq (
  input  usbep0_pkg::item_t                item,
  input  usbep0_pkg::ctx_t                 ctx,
  input  logic [usbep0_pkg::MpsW-1:0]      mps,
  output usbep0_pkg::result_t              res,
  output usbep0_pkg::ctx_t                 ctx_nxt
);

  logic [usbep0_pkg::LenW-1:0] mps_ext;
  logic                        left_fits;
  logic                        len_fits;
  logic                        setup_ok;

  assign mps_ext   = {{(usbep0_pkg::LenW - usbep0_pkg::MpsW){1'b0}}, mps};
  assign left_fits = (item.in_bytes_left <= mps_ext);
  assign len_fits  = (ctx.saved_len <= mps_ext);
  assign setup_ok  = item.rx_ready_flag && (item.rx_count == usbep0_pkg::SetupCount);

  always_comb begin
    res             = '0;
    res.notify      = usbep0_pkg::NTF_NONE;
    res.phase       = ctx.phase;
    ctx_nxt         = ctx;

    if (item.kind == usbep0_pkg::KIND_SET_ADDR) begin
      // address zero goes out at once, others wait for the next event without a reported stall
      if (item.address == '0) begin
        res.address_write = 1'b1;
      end
      ctx_nxt.pend_addr = item.address;
    end else if (item.stalled_flag) begin
      res.clear_stalled = 1'b1;
      ctx_nxt.phase     = usbep0_pkg::PH_SETUP;
    end else begin
      res.clear_setup_end = item.setup_end_flag;
      if (ctx.pend_addr != '0) begin
        res.address_write = 1'b1;
        res.address_out   = ctx.pend_addr;
        ctx_nxt.pend_addr = '0;
      end
      case (ctx.phase)
        usbep0_pkg::PH_SETUP: begin
          if (setup_ok) begin
            ctx_nxt.saved_len = item.request_length;
            res.rx_done       = 1'b1;
            res.notify        = usbep0_pkg::NTF_SETUP;
            if (item.request_length == '0) begin
              res.data_end = 1'b1;
            end
            if (item.stall_request) begin
              res.send_stall = 1'b1;
              ctx_nxt.phase  = usbep0_pkg::PH_STALL;
            end else if (item.request_length != '0) begin
              if (item.request_in) begin
                res.tx_ready = 1'b1;
                if (left_fits) begin
                  res.data_end  = 1'b1;
                  ctx_nxt.phase = usbep0_pkg::PH_OUT_STATUS;
                end else begin
                  ctx_nxt.phase = usbep0_pkg::PH_IN_DATA;
                end
              end else begin
                ctx_nxt.phase = usbep0_pkg::PH_OUT_DATA;
              end
            end else begin
              res.tx_ready  = 1'b1;
              res.data_end  = 1'b1;
              ctx_nxt.phase = usbep0_pkg::PH_IN_STATUS;
            end
          end
        end
        usbep0_pkg::PH_IN_DATA: begin
          res.notify   = usbep0_pkg::NTF_IN;
          res.tx_ready = 1'b1;
          if (left_fits) begin
            res.data_end  = 1'b1;
            ctx_nxt.phase = usbep0_pkg::PH_OUT_STATUS;
          end
        end
        usbep0_pkg::PH_IN_STATUS,
        usbep0_pkg::PH_OUT_STATUS: begin
          ctx_nxt.phase = usbep0_pkg::PH_SETUP;
        end
        usbep0_pkg::PH_OUT_DATA: begin
          // total request length against packet size, not bytes remaining
          if (item.rx_ready_flag) begin
            res.notify  = usbep0_pkg::NTF_OUT;
            res.rx_done = 1'b1;
            if (len_fits) begin
              res.data_end  = 1'b1;
              ctx_nxt.phase = usbep0_pkg::PH_IN_STATUS;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.phase = ctx_nxt.phase;
  end

endmodule

// ----- rtl/usb_ep0_control_transfer_fsm_unit.sv -----
// endpoint-zero control-transfer sequencer, top level
//
// input channel in_*: one item is either a set-address request (in_kind 1)
// or an ep0 interrupt event with the controller flags and setup details.
// output channel out_*: exactly one command set per item, in item order.
// cfg channel: cfg_data writes the ep0 max packet size; cfg_ready is
// always high, writes are expected only while no item is in flight.
//
// an accepted item sits in the input register, is decoded against the
// phase, pending address and saved length, and lands in the output
// register, which drives out_valid. one item per cycle is sustained
// while out_ready stays high; the phase state is updated as each
// item moves from the input register to the output register.
//
// a stalled receiver holds the output register and then the input
// register; in_ready drops only when both are full and out_ready is low.
// reset puts the phase in setup, clears pending address and saved length,
// sets the max packet size to 64 and empties both registers.
module usb_ep0_control_transfer_fsm_unit (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [usbep0_pkg::AddrW-1:0]  in_address,
  input  logic                          in_stalled_flag,
  input  logic                          in_setup_end_flag,
  input  logic                          in_rx_ready_flag,
  input  logic [usbep0_pkg::CountW-1:0] in_rx_count,
  input  logic [usbep0_pkg::LenW-1:0]   in_request_length,
  input  logic                          in_request_in,
  input  logic                          in_stall_request,
  input  logic [usbep0_pkg::LenW-1:0]   in_in_bytes_left,

  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_notify,
  output logic                          out_clear_stalled,
  output logic                          out_clear_setup_end,
  output logic                          out_rx_done,
  output logic                          out_tx_ready,
  output logic                          out_data_end,
  output logic                          out_send_stall,
  output logic                          out_address_write,
  output logic [usbep0_pkg::AddrW-1:0]  out_address_out,
  output logic [2:0]                    out_phase,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [usbep0_pkg::MpsW-1:0]   cfg_data
);

`include "usb_ep0_control_transfer_fsm_unit_defines.svh"

  logic                          in_vld_r;
  usbep0_pkg::item_t             item_r;
  logic                          out_vld_r;
  usbep0_pkg::result_t           res_r;
  usbep0_pkg::ctx_t              ctx_r;
  usbep0_pkg::ctx_t              ctx_nxt;
  usbep0_pkg::result_t           res_nxt;
  logic [usbep0_pkg::MpsW-1:0]   mps_r;
  usbep0_pkg::item_t             item_in;
  logic                          advance;
  logic                          in_fire;

  assign item_in.kind           = in_kind;
  assign item_in.address        = in_address;
  assign item_in.stalled_flag   = in_stalled_flag;
  assign item_in.setup_end_flag = in_setup_end_flag;
  assign item_in.rx_ready_flag  = in_rx_ready_flag;
  assign item_in.rx_count       = in_rx_count;
  assign item_in.request_length = in_request_length;
  assign item_in.request_in     = in_request_in;
  assign item_in.stall_request  = in_stall_request;
  assign item_in.in_bytes_left  = in_in_bytes_left;

  // input register moves on when the output register is free or draining
  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  usbep0_seq u_seq (
    .item    (item_r),
    .ctx     (ctx_r),
    .mps     (mps_r),
    .res     (res_nxt),
    .ctx_nxt (ctx_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r        <= 1'b0;
      out_vld_r       <= 1'b0;
      ctx_r.phase     <= usbep0_pkg::PH_SETUP;
      ctx_r.pend_addr <= '0;
      ctx_r.saved_len <= '0;
      mps_r           <= usbep0_pkg::MpsReset;
    end else begin
      if (in_fire) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        ctx_r     <= ctx_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_valid) begin
        mps_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= item_in;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_vld_r;
  assign out_notify          = res_r.notify;
  assign out_clear_stalled   = res_r.clear_stalled;
  assign out_clear_setup_end = res_r.clear_setup_end;
  assign out_rx_done         = res_r.rx_done;
  assign out_tx_ready        = res_r.tx_ready;
  assign out_data_end        = res_r.data_end;
  assign out_send_stall      = res_r.send_stall;
  assign out_address_write   = res_r.address_write;
  assign out_address_out     = res_r.address_out;
  assign out_phase           = res_r.phase;

  `USBEP0_ASSERT_NOW(a_addr_zero_idle, clk, rst_n,
    out_vld_r && !res_r.address_write, res_r.address_out == '0,
    "address_out nonzero without address_write")
  `USBEP0_ASSERT_NOW(a_stall_phase, clk, rst_n,
    out_vld_r && res_r.send_stall, res_r.phase == usbep0_pkg::PH_STALL,
    "stall commanded without entering stall phase")
  `USBEP0_ASSERT_NEXT(a_stall_to_setup, clk, rst_n,
    advance && (item_r.kind == usbep0_pkg::KIND_EVENT) && item_r.stalled_flag,
    ctx_r.phase == usbep0_pkg::PH_SETUP,
    "reported stall did not return to setup phase")
  `USBEP0_ASSERT_NEXT(a_pend_cleared, clk, rst_n,
    advance && (item_r.kind == usbep0_pkg::KIND_EVENT) && !item_r.stalled_flag,
    ctx_r.pend_addr == '0,
    "pending address not cleared by an event")
  `USBEP0_ASSERT_NEXT(a_accept_held, clk, rst_n,
    in_fire, in_vld_r,
    "accepted item not held in the input register")

endmodule

// ----- tb/usb_ep0_control_transfer_fsm_unit_test.sv -----
// self-checking testbench of the endpoint-zero control-transfer sequencer
module usb_ep0_control_transfer_fsm_unit_test;
  import usbep0_pkg::*;

  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } row_t;

  localparam int NumDirected = 25;

  localparam item_t Quiet = '{KIND_EVENT, 7'd0, 0, 0, 0, 7'd0, 16'd0, 0, 0, 16'd0};
  localparam result_t NoCmd = '{NTF_NONE, 0, 0, 0, 0, 0, 0, 0, 7'd0, PH_SETUP};
  localparam result_t StallCleared = '{NTF_NONE, 1, 0, 0, 0, 0, 0, 0, 7'd0, PH_SETUP};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic  in_valid = 1'b0;
  logic  in_ready;
  item_t in_item = '0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_notify;
  logic             out_clear_stalled;
  logic             out_clear_setup_end;
  logic             out_rx_done;
  logic             out_tx_ready;
  logic             out_data_end;
  logic             out_send_stall;
  logic             out_address_write;
  logic [AddrW-1:0] out_address_out;
  logic [2:0]       out_phase;

  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [MpsW-1:0] cfg_data = '0;

  // shadow of the sequencer state
  phase_t          track_phase = PH_SETUP;
  logic [AddrW-1:0] track_pend = '0;
  logic [LenW-1:0] track_len = '0;
  logic [MpsW-1:0] track_mps = MpsReset;

  result_t pending_cmds[$];
  int      mismatches = 0;
  int      results_seen = 0;
  bit      calm = 1'b0;
  int      rdy_hold = 0;

  row_t directed_rows [NumDirected] = '{
    '{Quiet, 1'b1, NoCmd},
    '{'{KIND_SET_ADDR, 7'd0, 0, 0, 0, 7'd0, 16'd0, 0, 0, 16'd0}, 1'b1,
      '{NTF_NONE, 0, 0, 0, 0, 0, 0, 1, 7'd0, PH_SETUP}},
    '{'{KIND_SET_ADDR, 7'd127, 1, 1, 1, 7'd127, 16'hFFFF, 1, 1, 16'hFFFF}, 1'b1, NoCmd},
    '{'{KIND_EVENT, 7'd127, 1, 1, 1, 7'd8, 16'd0, 1, 1, 16'd0}, 1'b1, StallCleared},
    '{'{KIND_EVENT, 7'd0, 0, 1, 1, 7'd7, 16'd0, 0, 0, 16'd0}, 1'b1,
      '{NTF_NONE, 0, 1, 0, 0, 0, 0, 1, 7'd127, PH_SETUP}},
    '{'{KIND_EVENT, 7'd0, 0, 0, 1, 7'd127, 16'd0, 0, 0, 16'd0}, 1'b1, NoCmd},
    '{'{KIND_EVENT, 7'd0, 0, 0, 1, 7'd8, 16'd0, 0, 0, 16'd0}, 1'b1,
      '{NTF_SETUP, 0, 0, 1, 1, 1, 0, 0, 7'd0, PH_IN_STATUS}},
    '{Quiet, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 0, 0, 1, 7'd8, 16'hFFFF, 1, 0, 16'hFFFF}, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 0, 0, 0, 7'd0, 16'd0, 0, 0, 16'd65}, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 0, 0, 0, 7'd0, 16'd0, 0, 0, 16'd64}, 1'b0, NoCmd},
    '{Quiet, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 0, 0, 1, 7'd8, 16'd64, 0, 0, 16'd0}, 1'b0, NoCmd},
    '{Quiet, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 0, 0, 1, 7'd0, 16'd0, 0, 0, 16'd0}, 1'b0, NoCmd},
    '{Quiet, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 0, 0, 1, 7'd8, 16'd65, 0, 0, 16'd0}, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 0, 0, 1, 7'd8, 16'd0, 0, 0, 16'd0}, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 1, 0, 0, 7'd0, 16'd0, 0, 0, 16'd0}, 1'b1, StallCleared},
    '{'{KIND_EVENT, 7'd0, 0, 0, 1, 7'd8, 16'd5, 0, 1, 16'd0}, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 0, 1, 1, 7'd8, 16'd0, 0, 0, 16'd0}, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 1, 0, 0, 7'd0, 16'd0, 0, 0, 16'd0}, 1'b1, StallCleared},
    '{'{KIND_SET_ADDR, 7'h55, 0, 0, 0, 7'd0, 16'd0, 0, 0, 16'd0}, 1'b0, NoCmd},
    '{'{KIND_EVENT, 7'd0, 0, 0, 1, 7'd8, 16'd100, 1, 0, 16'd0}, 1'b0, NoCmd},
    '{Quiet, 1'b0, NoCmd}
  };

  logic [MpsW-1:0] mps_settings [5] = '{7'd8, 7'd127, 7'd0, 7'd0, 7'd64};

  usb_ep0_control_transfer_fsm_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_item.kind),
    .in_address          (in_item.address),
    .in_stalled_flag     (in_item.stalled_flag),
    .in_setup_end_flag   (in_item.setup_end_flag),
    .in_rx_ready_flag    (in_item.rx_ready_flag),
    .in_rx_count         (in_item.rx_count),
    .in_request_length   (in_item.request_length),
    .in_request_in       (in_item.request_in),
    .in_stall_request    (in_item.stall_request),
    .in_in_bytes_left    (in_item.in_bytes_left),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_notify          (out_notify),
    .out_clear_stalled   (out_clear_stalled),
    .out_clear_setup_end (out_clear_setup_end),
    .out_rx_done         (out_rx_done),
    .out_tx_ready        (out_tx_ready),
    .out_data_end        (out_data_end),
    .out_send_stall      (out_send_stall),
    .out_address_write   (out_address_write),
    .out_address_out     (out_address_out),
    .out_phase           (out_phase),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // command set for one item, advancing the shadow state
  function automatic result_t ep0_commands(item_t it);
    result_t r;
    r = NoCmd;
    if (it.kind == KIND_SET_ADDR) begin
      // address zero takes effect at once, others wait for the next event without a reported stall
      if (it.address == '0) r.address_write = 1'b1;
      track_pend = it.address;
    end else if (it.stalled_flag) begin
      r.clear_stalled = 1'b1;
      track_phase = PH_SETUP;
    end else begin
      r.clear_setup_end = it.setup_end_flag;
      if (track_pend != '0) begin
        r.address_write = 1'b1;
        r.address_out = track_pend;
        track_pend = '0;
      end
      case (track_phase)
        PH_SETUP: begin
          if (it.rx_ready_flag && it.rx_count == SetupCount) begin
            track_len = it.request_length;
            r.rx_done = 1'b1;
            r.notify = NTF_SETUP;
            r.data_end = (it.request_length == '0);
            if (it.stall_request) begin
              r.send_stall = 1'b1;
              track_phase = PH_STALL;
            end else if (it.request_length != '0) begin
              if (it.request_in) begin
                r.tx_ready = 1'b1;
                if (it.in_bytes_left <= track_mps) begin
                  r.data_end = 1'b1;
                  track_phase = PH_OUT_STATUS;
                end else begin
                  track_phase = PH_IN_DATA;
                end
              end else begin
                track_phase = PH_OUT_DATA;
              end
            end else begin
              r.tx_ready = 1'b1;
              r.data_end = 1'b1;
              track_phase = PH_IN_STATUS;
            end
          end
        end
        PH_IN_DATA: begin
          r.notify = NTF_IN;
          r.tx_ready = 1'b1;
          if (it.in_bytes_left <= track_mps) begin
            r.data_end = 1'b1;
            track_phase = PH_OUT_STATUS;
          end
        end
        PH_IN_STATUS, PH_OUT_STATUS: begin
          track_phase = PH_SETUP;
        end
        PH_OUT_DATA: begin
          if (it.rx_ready_flag) begin
            r.notify = NTF_OUT;
            r.rx_done = 1'b1;
            // total request length, not the bytes still to come
            if (track_len <= track_mps) begin
              r.data_end = 1'b1;
              track_phase = PH_IN_STATUS;
            end
          end
        end
        default: begin
        end
      endcase
    end
    r.phase = track_phase;
    return r;
  endfunction

  // mostly well-formed transfers for the current phase, some noise
  function automatic item_t random_event();
    item_t it;
    int roll;
    it.kind = 1'($urandom);
    it.address = 7'($urandom);
    it.stalled_flag = 1'($urandom);
    it.setup_end_flag = 1'($urandom);
    it.rx_ready_flag = 1'($urandom);
    it.rx_count = 7'($urandom);
    it.request_length = 16'($urandom);
    it.request_in = 1'($urandom);
    it.stall_request = 1'($urandom);
    it.in_bytes_left = 16'($urandom);
    roll = int'($urandom_range(0, 99));
    if (roll < 10) return it;
    it.kind = KIND_EVENT;
    it.stalled_flag = 1'b0;
    it.setup_end_flag = ($urandom_range(0, 9) == 0);
    if (roll < 18) begin
      it.kind = KIND_SET_ADDR;
      if ($urandom_range(0, 3) == 0) it.address = '0;
    end else if (roll < 23) begin
      it.stalled_flag = 1'b1;
    end else begin
      if ($urandom_range(0, 5) != 0) it.in_bytes_left = 16'($urandom_range(0, 140));
      case (track_phase)
        PH_SETUP: begin
          it.rx_ready_flag = ($urandom_range(0, 9) != 0);
          if ($urandom_range(0, 9) != 0) it.rx_count = SetupCount;
          case ($urandom_range(0, 5))
            0: it.request_length = '0;
            1: it.request_length = 16'hFFFF;
            2: begin
            end
            default: it.request_length = 16'($urandom_range(1, 200));
          endcase
          it.stall_request = ($urandom_range(0, 9) == 0);
        end
        PH_OUT_DATA: it.rx_ready_flag = ($urandom_range(0, 6) != 0);
        PH_STALL: it.stalled_flag = ($urandom_range(0, 9) < 7);
        default: begin
        end
      endcase
    end
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic send_item(input item_t it);
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic maybe_pause_input();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // register writes only once the block has drained
  task automatic write_max_packet(input logic [MpsW-1:0] value);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    track_mps = value;
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rdy_hold != 0) begin
      out_ready <= 1'b0;
      rdy_hold <= rdy_hold - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rdy_hold <= int'($urandom_range(0, 4));
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{notify_t'(out_notify), out_clear_stalled, out_clear_setup_end, out_rx_done,
              out_tx_ready, out_data_end, out_send_stall, out_address_write,
              out_address_out, phase_t'(out_phase)};
      if (pending_cmds.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_cmds.pop_front();
        check_field("notify", got.notify, want.notify);
        check_field("clear_stalled", got.clear_stalled, want.clear_stalled);
        check_field("clear_setup_end", got.clear_setup_end, want.clear_setup_end);
        check_field("rx_done", got.rx_done, want.rx_done);
        check_field("tx_ready", got.tx_ready, want.tx_ready);
        check_field("data_end", got.data_end, want.data_end);
        check_field("send_stall", got.send_stall, want.send_stall);
        check_field("address_write", got.address_write, want.address_write);
        check_field("address_out", got.address_out, want.address_out);
        check_field("phase", got.phase, want.phase);
      end
      results_seen++;
    end
  end

  initial begin
    result_t cmds;
    item_t it;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].stim);
      cmds = ep0_commands(directed_rows[i].stim);
      pending_cmds.push_back(directed_rows[i].typed ? directed_rows[i].want : cmds);
      maybe_pause_input();
    end

    for (int p = 0; p < 5; p++) begin
      write_max_packet(p == 3 ? 7'($urandom_range(8, 64)) : mps_settings[p]);
      // last stretch runs at full rate on both sides
      calm = (p == 4);
      repeat (100) begin
        it = random_event();
        send_item(it);
        pending_cmds.push_back(ep0_commands(it));
        maybe_pause_input();
      end
    end

    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
